// File: hw/rtl/rational_exponent_power_reduce_assert.svh
// Assertion macros shared by the rational exponent power reduction RTL.
// Depends on nothing; files that assert include it by name.
`ifndef RATIONAL_EXPONENT_POWER_REDUCE_ASSERT_SVH
`define RATIONAL_EXPONENT_POWER_REDUCE_ASSERT_SVH

// Clocked assertion with an explicit clock and active low reset.
`define REP_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the house clock and reset names.
`define REP_ASSERT_STD(lbl, prop, msg) `REP_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// File: hw/rtl/rep_pkg.sv
// Package for the rational exponent power reduction block: widths, types and helpers.
// Depends on nothing; used by every module of the block.
package rep_pkg;

	localparam int OperandWidth = 16;
	localparam int ProdWidth    = 2 * OperandWidth;
	localparam int NumerWidth   = 32;
	localparam int DenomWidth   = 31;
	localparam int ExtWidth     = (ProdWidth > NumerWidth) ? ProdWidth : NumerWidth;
	localparam int CountWidth   = $clog2(ProdWidth);

	typedef logic [OperandWidth-1:0] opnd_t;
	typedef logic [ProdWidth-1:0]    prod_t;
	typedef logic [ExtWidth-1:0]     ext_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	function automatic opnd_t mag_of(input opnd_t v);
		opnd_t neg_v;
		neg_v = opnd_t'(~v + opnd_t'(1));
		return v[OperandWidth-1] ? neg_v : v;
	endfunction

endpackage

// File: hw/rtl/rep_gcd.sv
// Iterative binary greatest common divisor unit, one shift or subtract step a cycle.
// Depends on rep_pkg; both operands must be nonzero at start.
module rep_gcd (
	input  logic              clk,
	input  logic              arst_n,
	input  rep_pkg::unit_ctl_t ctl,
	input  rep_pkg::prod_t    a_in,
	input  rep_pkg::prod_t    b_in,
	output rep_pkg::unit_sts_t sts,
	output rep_pkg::prod_t    g
);
	import rep_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} gcd_state_t;

	gcd_state_t            state_q;
	prod_t                 a_q;
	prod_t                 b_q;
	logic [CountWidth-1:0] k_q;
	prod_t                 g_q;
	logic                  done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						a_q     <= a_in;
						b_q     <= b_in;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (a_q == b_q) begin
						g_q     <= prod_t'(a_q << k_q);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + CountWidth'(1);
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_q > b_q) begin
						a_q <= prod_t'(a_q - b_q) >> 1;
					end else begin
						b_q <= prod_t'(b_q - a_q) >> 1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sts.busy = (state_q != ST_IDLE);
	assign sts.done = done_q;
	assign g        = g_q;

endmodule

// File: hw/rtl/rep_div.sv
// Restoring divider, one quotient bit a cycle, used for both exact divisions.
// Depends on rep_pkg; the divisor must be nonzero at start.
module rep_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rep_pkg::unit_ctl_t ctl,
	input  rep_pkg::prod_t    dividend,
	input  rep_pkg::prod_t    divisor,
	output rep_pkg::unit_sts_t sts,
	output rep_pkg::prod_t    quotient
);
	import rep_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} div_state_t;

	div_state_t            state_q;
	prod_t                 rem_q;
	prod_t                 quo_q;
	prod_t                 dvs_q;
	logic [CountWidth-1:0] cnt_q;
	logic                  done_q;
	logic [ProdWidth:0]    shifted;
	logic [ProdWidth:0]    trial;
	logic                  fits;

	assign shifted = {rem_q, quo_q[ProdWidth-1]};
	assign fits    = (shifted >= {1'b0, dvs_q});
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						rem_q   <= '0;
						quo_q   <= dividend;
						dvs_q   <= divisor;
						cnt_q   <= CountWidth'(ProdWidth - 1);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					rem_q <= fits ? trial[ProdWidth-1:0] : shifted[ProdWidth-1:0];
					quo_q <= {quo_q[ProdWidth-2:0], fits};
					cnt_q <= cnt_q - CountWidth'(1);
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sts.busy = (state_q != ST_IDLE);
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/rational_exponent_power_reduce.sv
// Top level of the rational exponent power reduction block: sequencer and shared multiplier.
// Depends on rep_pkg, rep_gcd, rep_div and rational_exponent_power_reduce_assert.svh.
//
// Channel   Direction  Handshake                  Words
// command   in         start high while busy low  base_numer, base_denom, exp_numer, exp_denom
// result    out        done high for one cycle    result_numer, result_denom, zero_denominator
//
// One word is in flight at a time; busy stays high from acceptance until the result is shown.
// A zero product numerator or denominator raises done from ST_CHECK, after ST_MUL_N and
// ST_MUL_D have formed the two products. Otherwise the binary GCD loop runs, and the shared
// restoring divider then performs the two divisions, numerator first and denominator second.
// Reset clears the sequencer and strobes only; the receiver cannot stall results.
`include "rational_exponent_power_reduce_assert.svh"

module rational_exponent_power_reduce (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [rep_pkg::OperandWidth-1:0] base_numer,
	input  logic signed [rep_pkg::OperandWidth-1:0] base_denom,
	input  logic signed [rep_pkg::OperandWidth-1:0] exp_numer,
	input  logic signed [rep_pkg::OperandWidth-1:0] exp_denom,
	output logic                                 done,
	output logic signed [rep_pkg::NumerWidth-1:0]   result_numer,
	output logic        [rep_pkg::DenomWidth-1:0]   result_denom,
	output logic                                 zero_denominator
);
	import rep_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL_N, ST_MUL_D, ST_CHECK, ST_GCD, ST_DIV_N, ST_DIV_D
	} top_state_t;

	top_state_t state_q;
	opnd_t      bn_q;
	opnd_t      bd_q;
	opnd_t      en_q;
	opnd_t      ed_q;
	logic       neg_q;
	prod_t      num_q;
	prod_t      den_q;
	prod_t      g_q;
	prod_t      rn_q;
	unit_ctl_t  gcd_ctl_q;
	unit_ctl_t  div_ctl_q;
	unit_sts_t  gcd_sts;
	unit_sts_t  div_sts;
	prod_t      gcd_g;
	prod_t      div_quo;
	prod_t      div_dividend;
	opnd_t      mul_a;
	opnd_t      mul_b;
	prod_t      prod;
	ext_t       rn_ext;
	ext_t       rn_neg;
	ext_t       rd_ext;

	logic                         done_q;
	logic                         zero_q;
	logic signed [NumerWidth-1:0] numer_q;
	logic        [DenomWidth-1:0] denom_q;

	assign mul_a        = (state_q == ST_MUL_N) ? bn_q : bd_q;
	assign mul_b        = (state_q == ST_MUL_N) ? en_q : ed_q;
	assign prod         = prod_t'(mul_a) * prod_t'(mul_b);
	assign div_dividend = (state_q == ST_DIV_D) ? den_q : num_q;
	assign rn_ext       = ext_t'(rn_q);
	assign rn_neg       = ext_t'(~rn_ext + ext_t'(1));
	assign rd_ext       = ext_t'(div_quo);

	rep_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (gcd_ctl_q),
		.a_in   (num_q),
		.b_in   (den_q),
		.sts    (gcd_sts),
		.g      (gcd_g)
	);

	rep_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl_q),
		.dividend (div_dividend),
		.divisor  (g_q),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			gcd_ctl_q <= '0;
			div_ctl_q <= '0;
		end else begin
			done_q    <= 1'b0;
			gcd_ctl_q <= '0;
			div_ctl_q <= '0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						bn_q    <= mag_of(opnd_t'(base_numer));
						bd_q    <= mag_of(opnd_t'(base_denom));
						en_q    <= mag_of(opnd_t'(exp_numer));
						ed_q    <= mag_of(opnd_t'(exp_denom));
						neg_q   <= base_numer[OperandWidth-1] ^ base_denom[OperandWidth-1] ^
							exp_numer[OperandWidth-1] ^ exp_denom[OperandWidth-1];
						state_q <= ST_MUL_N;
					end
				end
				ST_MUL_N: begin
					num_q   <= prod;
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: begin
					den_q   <= prod;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (den_q == '0) begin
						numer_q <= '0;
						denom_q <= '0;
						zero_q  <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (num_q == '0) begin
						numer_q <= '0;
						denom_q <= DenomWidth'(1);
						zero_q  <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						gcd_ctl_q.start <= 1'b1;
						state_q         <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (gcd_sts.done) begin
						g_q             <= gcd_g;
						div_ctl_q.start <= 1'b1;
						state_q         <= ST_DIV_N;
					end
				end
				ST_DIV_N: begin
					if (div_sts.done) begin
						rn_q            <= div_quo;
						div_ctl_q.start <= 1'b1;
						state_q         <= ST_DIV_D;
					end
				end
				ST_DIV_D: begin
					if (div_sts.done) begin
						numer_q <= neg_q ? rn_neg[NumerWidth-1:0] : rn_ext[NumerWidth-1:0];
						denom_q <= rd_ext[DenomWidth-1:0];
						zero_q  <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy             = (state_q != ST_IDLE);
	assign done             = done_q;
	assign result_numer     = numer_q;
	assign result_denom     = denom_q;
	assign zero_denominator = zero_q;

	`REP_ASSERT_STD(a_done_after_busy, done |-> $past(busy), "Result shown without a word in flight")
	`REP_ASSERT_STD(a_accept_sets_busy, (start && !busy) |=> busy, "Accepted word did not raise busy")
	`REP_ASSERT_STD(a_error_zero, (done && zero_denominator) |-> (result_numer == 0 && result_denom == 0), "Error result is not 0/0")
	`REP_ASSERT_STD(a_denom_nonzero, (done && !zero_denominator) |-> (result_denom != 0), "Valid result has zero denominator")
	`REP_ASSERT_STD(a_units_idle, !busy |-> (!gcd_sts.busy && !div_sts.busy), "Shared unit busy while sequencer idle")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for rational_exponent_power_reduce: drives command words
// and checks each reduced fraction against a predictor written in this file.
// Depends on rep_pkg and the RTL of the block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rep_pkg::*;

	localparam int Msb        = OperandWidth - 1;
	localparam int CycleLimit = 1000000;
	localparam int TailCycles = 200;

	typedef struct packed {
		opnd_t bn;
		opnd_t bd;
		opnd_t en;
		opnd_t ed;
	} cmd_word_t;

	typedef struct packed {
		logic [NumerWidth-1:0] numer;
		logic [DenomWidth-1:0] denom;
		logic                  zden;
	} fraction_t;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic signed [OperandWidth-1:0] base_numer;
	logic signed [OperandWidth-1:0] base_denom;
	logic signed [OperandWidth-1:0] exp_numer;
	logic signed [OperandWidth-1:0] exp_denom;
	logic                           done;
	logic signed [NumerWidth-1:0]   result_numer;
	logic        [DenomWidth-1:0]   result_denom;
	logic                           zero_denominator;

	fraction_t pending_fractions[$];
	fraction_t want;
	int        mismatches;
	int        idle_pct;

	rational_exponent_power_reduce u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.base_numer       (base_numer),
		.base_denom       (base_denom),
		.exp_numer        (exp_numer),
		.exp_denom        (exp_denom),
		.done             (done),
		.result_numer     (result_numer),
		.result_denom     (result_denom),
		.zero_denominator (zero_denominator)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint unsigned opnd_magnitude(opnd_t v);
		opnd_t           t;
		longint unsigned m;
		t = v[Msb] ? opnd_t'(~v + 1'b1) : v;
		m = 0;
		m[OperandWidth-1:0] = t;
		return m;
	endfunction

	function automatic fraction_t reduce_power(cmd_word_t w);
		longint unsigned num;
		longint unsigned den;
		longint unsigned a;
		longint unsigned b;
		longint unsigned r;
		longint unsigned sn;
		logic            neg;
		fraction_t       res;
		num = opnd_magnitude(w.bn) * opnd_magnitude(w.en);
		den = opnd_magnitude(w.bd) * opnd_magnitude(w.ed);
		neg = w.bn[Msb] ^ w.bd[Msb] ^ w.en[Msb] ^ w.ed[Msb];
		if (den == 0) begin
			res = '{numer: '0, denom: '0, zden: 1'b1};
		end else if (num == 0) begin
			res = '{numer: '0, denom: DenomWidth'(1), zden: 1'b0};
		end else begin
			a = num;
			b = den;
			while (b != 0) begin
				r = a % b;
				a = b;
				b = r;
			end
			sn = neg ? (64'd0 - num / a) : num / a;
			res.numer = sn[NumerWidth-1:0];
			res.denom = DenomWidth'(den / a);
			res.zden  = 1'b0;
		end
		return res;
	endfunction

	function automatic cmd_word_t make_word(int bn, int bd, int en, int ed);
		cmd_word_t w;
		w.bn = opnd_t'(bn);
		w.bd = opnd_t'(bd);
		w.en = opnd_t'(en);
		w.ed = opnd_t'(ed);
		return w;
	endfunction

	function automatic opnd_t rand_factored();
		int m;
		m = $urandom_range(1, 255) << $urandom_range(0, 7);
		return opnd_t'($urandom_range(0, 1) ? -m : m);
	endfunction

	function automatic opnd_t rand_edge_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return opnd_t'(1);
			2: return '1;
			3: return {1'b0, {Msb{1'b1}}};
			4: return {1'b1, {Msb{1'b0}}};
			5: return rand_factored();
			default: return opnd_t'($urandom());
		endcase
	endfunction

	task automatic send_word(cmd_word_t w);
		while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
		@(negedge clk);
		start      <= 1'b1;
		base_numer <= w.bn;
		base_denom <= w.bd;
		exp_numer  <= w.en;
		exp_denom  <= w.ed;
		do @(posedge clk); while (busy !== 1'b0);
		pending_fractions.push_back(reduce_power(w));
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic wait_fractions_drained();
		while (pending_fractions.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_fractions.size() == 0) begin
				$error("result word with no expectation: numer %0d denom %0d",
					result_numer, result_denom);
				mismatches++;
			end else begin
				want = pending_fractions.pop_front();
				if (result_numer !== want.numer) begin
					$error("result_numer: expected %0d, actual %0d",
						$signed(want.numer), result_numer);
					mismatches++;
				end
				if (result_denom !== want.denom) begin
					$error("result_denom: expected %0d, actual %0d",
						want.denom, result_denom);
					mismatches++;
				end
				if (zero_denominator !== want.zden) begin
					$error("zero_denominator: expected %0b, actual %0b",
						want.zden, zero_denominator);
					mismatches++;
				end
			end
		end
	end

	task automatic test_directed_corners();
		send_word(make_word(1, 1, 1, 1));
		send_word(make_word(3, 6, 1, 1));
		send_word(make_word(4, -6, 1, 1));
		send_word(make_word(0, 5, 7, 3));
		send_word(make_word(0, -7, 0, -9));
		send_word(make_word(5, 0, 2, 3));
		send_word(make_word(5, 3, 2, 0));
		send_word(make_word(0, 0, 0, 0));
		send_word(make_word(0, 0, 5, 5));
		send_word(make_word(-32768, 0, 0, -32768));
		send_word(make_word(-32768, -32768, -32768, -32768));
		send_word(make_word(-32768, 1, -32768, 1));
		send_word(make_word(1, -32768, 1, -32768));
		send_word(make_word(-32768, 1, 32767, 1));
		send_word(make_word(32767, -32768, 32767, 32767));
		send_word(make_word(32767, 32767, 32767, 32767));
		send_word(make_word(-1, -1, -1, -1));
		send_word(make_word(-1, 1, 1, 1));
		send_word(make_word(2, 3, -3, 2));
		send_word(make_word(12345, -32768, -32768, 6));
		send_word(make_word(1, 32767, -1, -32767));
		send_word(make_word(-21846, 21845, 30030, -15015));
	endtask

	task automatic test_random_full_range(int count);
		repeat (count) begin
			send_word(make_word($urandom(), $urandom(), $urandom(), $urandom()));
		end
	endtask

	task automatic test_random_common_factors(int count);
		repeat (count) begin
			send_word({rand_factored(), rand_factored(), rand_factored(), rand_factored()});
		end
	endtask

	task automatic test_random_edge_mix(int count);
		repeat (count) begin
			send_word({rand_edge_value(), rand_edge_value(), rand_edge_value(),
				rand_edge_value()});
		end
	endtask

	task automatic test_sender_pause();
		repeat (3) begin
			wait_fractions_drained();
			send_word({rand_factored(), rand_factored(), rand_factored(), rand_factored()});
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		base_numer = '0;
		base_denom = '0;
		exp_numer  = '0;
		exp_denom  = '0;
		mismatches = 0;
		idle_pct   = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_corners();
		test_random_full_range(300);
		idle_pct = 67;
		test_random_common_factors(350);
		idle_pct = 34;
		test_random_full_range(250);
		test_sender_pause();
		idle_pct = 67;
		test_random_edge_mix(200);
		idle_pct = 0;
		test_random_common_factors(200);

		wait_fractions_drained();
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
